### rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants for the circular double-ended queue
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;
    localparam int CMD_W  = 2;
    localparam int STS_W  = 2;
    localparam int CAP_RESET = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [OCC_W-1:0]  occupancy;
        logic              pop_ok;
    } t_res;

    function automatic logic [CNT_W-1:0] limit_cap(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > DEPTH) begin
            r = CNT_W'(DEPTH);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

### rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WORDS  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// head, tail, count and capacity registers; decides each command's outcome
// and drives the ram address and write enable
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                        i_acc,
    input  cdq_pkg::t_cmd               i_cmd,
    output logic                        o_ram_we,
    output logic [cdq_pkg::ADDR_W-1:0]  o_ram_addr,
    output cdq_pkg::t_res               o_res
);

    import cdq_pkg::*;

    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_cap;

    logic [ADDR_W-1:0] head_dec, head_inc, tail_dec, tail_inc;
    logic              is_push;
    logic              full, empty;

    always_comb begin
        head_dec = (r_head == '0) ? ADDR_W'(r_cap - CNT_W'(1)) : r_head - ADDR_W'(1);
        tail_dec = (r_tail == '0) ? ADDR_W'(r_cap - CNT_W'(1)) : r_tail - ADDR_W'(1);
        head_inc = ((CNT_W'(r_head) + CNT_W'(1)) >= r_cap) ? '0 : r_head + ADDR_W'(1);
        tail_inc = ((CNT_W'(r_tail) + CNT_W'(1)) >= r_cap) ? '0 : r_tail + ADDR_W'(1);
        is_push  = (i_cmd == CMD_PUSH_FRONT) || (i_cmd == CMD_PUSH_BACK);
        full     = (r_count >= r_cap);
        empty    = (r_count == '0);
    end

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        o_ram_we      = 1'b0;
        o_ram_addr    = r_head;
        o_res.status  = ST_OK;
        o_res.pop_ok  = 1'b0;
        unique case (i_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_ram_we = i_acc;
                    n_count  = r_count + CNT_W'(1);
                    if (empty) begin
                        n_head     = '0;
                        n_tail     = '0;
                        o_ram_addr = '0;
                    end else if (i_cmd == CMD_PUSH_FRONT) begin
                        n_head     = head_dec;
                        o_ram_addr = head_dec;
                    end else begin
                        n_tail     = tail_inc;
                        o_ram_addr = tail_inc;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.pop_ok = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    if (i_cmd == CMD_POP_FRONT) begin
                        o_ram_addr = r_head;
                        n_head     = head_inc;
                    end else begin
                        o_ram_addr = r_tail;
                        n_tail     = tail_dec;
                    end
                    if (n_count == '0) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
        o_res.occupancy = OCC_W'(n_count);
        if (!is_push && !o_res.pop_ok) begin
            o_ram_addr = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= limit_cap(CAP_W'(CAP_RESET));
        end else if (i_cfg_we) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= limit_cap(i_cfg_data);
        end else if (i_acc) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

### rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue kept in a circular buffer of configurable capacity
// ----------------------------------------------------------------------------
// Each command word (push front, push back, pop front, pop back) yields one
// result word carrying status, popped value and occupancy after the command.
// Pushes and refused commands go straight from acceptance into the output
// register; a successful pop first passes through the ram read stage, since
// the value comes out of a single-port ram with registered read data. A new command is taken
// once the previous one has left the ram read stage and the output register
// is free or being drained. Writing the capacity (0 reads as 1, values above
// the built depth read as the depth) empties the queue.
module circular_deque (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]    i_cfg_data,     // capacity
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,   // push_value
    input  logic [1:0]                   s_axis_tuser,   // cmd
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [39:0]                  m_axis_tdata,   // popped_value, occupancy, zero pad
    output logic [1:0]                   m_axis_tuser    // status
);

    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;
    logic [OCC_W-1:0]    r_out_occ;
    t_status             r_out_status;
    logic [OCC_W-1:0]    r_pend_occ;

    logic                acc;
    logic                cfg_we;
    logic                out_free;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [VAL_W-1:0]    ram_rdata;
    t_res                res;

    assign o_cfg_ready   = (r_state == S_IDLE);
    assign cfg_we        = i_cfg_valid && o_cfg_ready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free && !i_cfg_valid;
    assign acc           = s_axis_tvalid && s_axis_tready;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_cmd      (t_cmd'(s_axis_tuser)),
        .o_ram_we   (ram_we),
        .o_ram_addr (ram_addr),
        .o_res      (res)
    );

    cdq_ram #(
        .WORDS  (DEPTH),
        .DATA_W (VAL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (s_axis_tdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && res.pop_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_out_valid <= 1'b1;
            end else if (acc && !res.pop_ok) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pend_occ <= res.occupancy;
            if (!res.pop_ok) begin
                r_out_value  <= '0;
                r_out_occ    <= res.occupancy;
                r_out_status <= res.status;
            end
        end else if (r_state == S_READ) begin
            r_out_value  <= ram_rdata;
            r_out_occ    <= r_pend_occ;
            r_out_status <= ST_OK;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(40 - VAL_W - OCC_W){1'b0}}, r_out_occ, r_out_value};
    assign m_axis_tuser  = r_out_status;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the circular double-ended queue
// ----------------------------------------------------------------------------
// A short table of commands and capacity writes is run first. It covers the
// empty and full refusals, the extreme values, the first word landing at both
// ends and the capacity limits, with hand-typed results where they are plain.
// Random phases follow, each under its own capacity. Each phase alternates
// between fill-heavy and drain-heavy runs so that the indices wrap. A
// behavioural copy of the deque predicts every result. Both stream sides idle
// in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
    import cdq_pkg::*;

    localparam int N_DIR       = 23;
    localparam int N_PHASES    = 10;
    localparam int PHASE_WORDS = 65;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] =
        '{5'd31, 5'd2, 5'd16, 5'd3, 5'd17, 5'd0, 5'd1, 5'd8, 5'd0, 5'd16};

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  popped;
        logic [OCC_W-1:0]  occ;
    } deque_res_t;

    typedef struct packed {
        logic              is_cfg;
        t_cmd              cmd;
        logic [VAL_W-1:0]  value;
        logic              typed;
        deque_res_t        res;
    } dir_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CAP_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;   // push_value
    logic [1:0]         s_axis_tuser = '0;   // cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;        // popped_value, occupancy, zero pad
    logic [1:0]         m_axis_tuser;        // status

    // deque copy used for prediction
    logic [VAL_W-1:0]   dq_mem [DEPTH];
    int                 front_idx = 0;
    int                 back_idx = 0;
    int                 fill = 0;
    int                 cap_used = CAP_RESET;

    deque_res_t         expected_q [$];
    deque_res_t         head_res;
    dir_row_t           dir_rows [N_DIR];
    int                 errors = 0;
    int                 cycles = 0;
    int                 stall_left = 0;
    bit                 quiet = 1'b0;

    circular_deque DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic deque_res_t next_deque_result(t_cmd c, logic [VAL_W-1:0] v);
        deque_res_t r;
        r = '{ST_OK, '0, '0};
        if (c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) begin
            if (fill >= cap_used) begin
                r.status = ST_FULL;
            end else begin
                if (fill == 0) begin
                    front_idx = 0;
                    back_idx  = 0;
                    dq_mem[0] = v;
                end else if (c == CMD_PUSH_FRONT) begin
                    front_idx = (front_idx == 0) ? cap_used - 1 : front_idx - 1;
                    dq_mem[front_idx] = v;
                end else begin
                    back_idx = (back_idx + 1 >= cap_used) ? 0 : back_idx + 1;
                    dq_mem[back_idx] = v;
                end
                fill++;
            end
        end else if (fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            if (c == CMD_POP_FRONT) begin
                r.popped  = dq_mem[front_idx];
                front_idx = (front_idx + 1 >= cap_used) ? 0 : front_idx + 1;
            end else begin
                r.popped = dq_mem[back_idx];
                back_idx = (back_idx == 0) ? cap_used - 1 : back_idx - 1;
            end
            fill--;
            if (fill == 0) begin
                front_idx = 0;
                back_idx  = 0;
            end
        end
        r.occ = OCC_W'(fill);
        return r;
    endfunction

    task automatic issue_command(t_cmd c, logic [VAL_W-1:0] v, bit typed,
                                 deque_res_t typed_res);
        deque_res_t r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = next_deque_result(c, v);
        expected_q.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    // only written with the result stream drained, so no word is in flight
    task automatic write_capacity(logic [CAP_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cap_used  = (v == '0) ? 1 : (int'(v) > DEPTH) ? DEPTH : int'(v);
        fill      = 0;
        front_idx = 0;
        back_idx  = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word, status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                head_res = expected_q.pop_front();
                if (m_axis_tuser != head_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head_res.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[31:0] != head_res.popped) begin
                    $display("%0t: popped value expected %h actual %h",
                             $time, head_res.popped, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[32 +: OCC_W] != head_res.occ) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, head_res.occ, m_axis_tdata[32 +: OCC_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[circular_deque] ERROR");
            $finish;
        end
    end

    initial begin
        t_cmd              c;
        logic [VAL_W-1:0]  v;
        logic [CAP_W-1:0]  cap_sel;
        bit                filling;
        bit                push_it;

        dir_rows = '{
            // empty after reset, capacity 16
            '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
            '{1'b0, CMD_POP_BACK,   32'hdead_beef, 1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
            // lone word sits at both ends
            '{1'b0, CMD_PUSH_BACK,  32'h7fff_ffff, 1'b1, '{ST_OK, 32'h0, 5'd1}},
            '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_OK, 32'h7fff_ffff, 5'd0}},
            '{1'b0, CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 5'd1}},
            '{1'b0, CMD_POP_BACK,   32'hffff_ffff, 1'b1, '{ST_OK, 32'h8000_0000, 5'd0}},
            '{1'b0, CMD_PUSH_FRONT, 32'hffff_ffff, 1'b1, '{ST_OK, 32'h0, 5'd1}},
            '{1'b0, CMD_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
            '{1'b0, CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
            '{1'b0, CMD_POP_BACK,   32'h0000_0000, 1'b0, '0},
            '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
            '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
            '{1'b0, CMD_POP_BACK,   32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
            // single-entry deque
            '{1'b1, CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
            '{1'b0, CMD_PUSH_BACK,  32'h1234_5678, 1'b1, '{ST_OK, 32'h0, 5'd1}},
            '{1'b0, CMD_PUSH_FRONT, 32'hffff_ffff, 1'b1, '{ST_FULL, 32'h0, 5'd1}},
            '{1'b0, CMD_PUSH_BACK,  32'h0000_0000, 1'b1, '{ST_FULL, 32'h0, 5'd1}},
            '{1'b0, CMD_POP_BACK,   32'h0000_0000, 1'b0, '0},
            '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
            // zero capacity behaves as one
            '{1'b1, CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
            '{1'b0, CMD_PUSH_FRONT, 32'ha5a5_a5a5, 1'b1, '{ST_OK, 32'h0, 5'd1}},
            '{1'b0, CMD_PUSH_BACK,  32'h5a5a_5a5a, 1'b1, '{ST_FULL, 32'h0, 5'd1}},
            '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].is_cfg) begin
                write_capacity(dir_rows[k].value[CAP_W-1:0]);
            end else begin
                issue_command(dir_rows[k].cmd, dir_rows[k].value, dir_rows[k].typed,
                              dir_rows[k].res);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            quiet   = (p == N_PHASES - 1);
            cap_sel = PHASE_CAPS[p];
            // two phases take a random capacity
            if (p == 5 || p == 8) begin
                cap_sel = $urandom_range(0, 31);
            end
            write_capacity(cap_sel);
            filling = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (fill >= cap_used) begin
                    filling = 1'b0;
                end else if (fill == 0) begin
                    filling = 1'b1;
                end else if ($urandom_range(0, 15) == 0) begin
                    filling = !filling;
                end
                if ($urandom_range(0, 9) == 0) begin
                    c = t_cmd'($urandom_range(0, 3));
                end else begin
                    push_it = filling ? ($urandom_range(0, 9) < 8)
                                      : ($urandom_range(0, 9) < 2);
                    if (push_it) begin
                        c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                    end else begin
                        c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                    end
                end
                v = $urandom;
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h7fff_ffff;
                        1: v = 32'h8000_0000;
                        2: v = 32'h0000_0000;
                        default: v = 32'hffff_ffff;
                    endcase
                end
                issue_command(c, v, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (errors == 0) begin
            $display("[circular_deque] OK");
        end else begin
            $display("[circular_deque] ERROR");
        end
        $finish;
    end

endmodule
